// File: rtl/mpfm_pkg.sv
// Package for the median pulse frequency meter.
// Shared widths, reset values, register codes and types; no dependencies.
`timescale 1ns / 1ps
package mpfm_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int HISTORY_DEF  = 10;

	localparam int TS_W   = 32;
	localparam int IVL_W  = 16;
	localparam int FREQ_W = 20;
	localparam int CNT_W  = 16;
	localparam int MINS_W = 4;
	localparam int CHAN_W = 2;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] CFG_GLITCH_MIN = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_ACCEPT_MIN = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_ACCEPT_MAX = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_MIN_SAMPLES = 2'd3;

	localparam logic [IVL_W-1:0]  GLITCH_RST = 16'd40;
	localparam logic [IVL_W-1:0]  AMIN_RST   = 16'd150;
	localparam logic [IVL_W-1:0]  AMAX_RST   = 16'd450;
	localparam logic [MINS_W-1:0] MINS_RST   = 4'd3;

	localparam logic [FREQ_W-1:0] FREQ_NUM = 20'd1000000;

	localparam logic OP_PULSE  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam int QDEPTH = 2;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [IVL_W-1:0]  glitch_min;
		logic [IVL_W-1:0]  accept_min;
		logic [IVL_W-1:0]  accept_max;
		logic [MINS_W-1:0] min_samples;
	} cfg_t;

	typedef struct packed {
		logic              report;
		logic [CHAN_W-1:0] chan;
		logic [TS_W-1:0]   ts;
	} cmd_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} qstat_t;

	typedef struct packed {
		logic reporting;
	} bstat_t;

endpackage

// File: rtl/mpfm_cmd_if.sv
// Command channel interface: valid/ready with opcode, channel and timestamp.
// Depends on mpfm_pkg.
`timescale 1ns / 1ps
interface mpfm_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [mpfm_pkg::CHAN_W-1:0] channel;
	logic [mpfm_pkg::TS_W-1:0]   timestamp_us;

	modport source(output valid, output opcode, output channel, output timestamp_us,
		input ready);
	modport sink(input valid, input opcode, input channel, input timestamp_us,
		output ready);
endinterface

// File: rtl/mpfm_res_if.sv
// Result channel interface: valid/ready with one report line.
// Depends on mpfm_pkg.
`timescale 1ns / 1ps
interface mpfm_res_if;
	logic                        valid;
	logic                        ready;
	logic [mpfm_pkg::CHAN_W-1:0] out_channel;
	logic [mpfm_pkg::FREQ_W-1:0] frequency_hz;
	logic [mpfm_pkg::CNT_W-1:0]  pulse_total;
	logic                        last_of_report;

	modport source(output valid, output out_channel, output frequency_hz,
		output pulse_total, output last_of_report, input ready);
	modport sink(input valid, input out_channel, input frequency_hz,
		input pulse_total, input last_of_report, output ready);
endinterface

// File: rtl/median_pulse_frequency_meter_core.sv
// Top level of the median pulse frequency meter: configuration registers,
// command front end and measurement back end. Depends on mpfm_pkg, the
// interfaces, mpfm_front and mpfm_back.
//
//   channel   dir   handshake        payload
//   cmd       in    valid/ready      opcode, channel, timestamp_us
//   res       out   valid/ready      out_channel, frequency_hz, pulse_total, last_of_report
//   cfg       in    cfg_wen          cfg_index, cfg_data (no read-back)
//
// A pulse waits in the two-entry command queue until the back end is idle,
// and the back end then does the edge bookkeeping for it.
// A report visits each active channel in turn: one ring memory read per
// history slot into the insertion sorter, then a restoring divider (skipped
// when too few intervals are stored), then the result register, which waits
// while res stalls.
// Reset is asynchronous and clears all channel state at once (valid bits on
// the ring), so items are taken from the first cycle after reset.
// The queue takes new commands, up to its depth, while the back end waits on res.
`timescale 1ns / 1ps
module median_pulse_frequency_meter_core #(
	parameter int CHANNELS      = mpfm_pkg::CHANNELS_DEF,
	parameter int HISTORY_DEPTH = mpfm_pkg::HISTORY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mpfm_cmd_if.sink                    cmd,
	mpfm_res_if.source                  res,
	input  logic                        cfg_wen,
	input  logic [mpfm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mpfm_pkg::CFG_DW-1:0] cfg_data
);
	mpfm_pkg::cfg_t   cfg_q;
	mpfm_pkg::cmd_t   q_cmd;
	mpfm_pkg::qstat_t qstat;
	mpfm_pkg::bstat_t bstat;
	logic             q_valid, q_pop;

	// hold the configuration; the user must write only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glitch_min  <= mpfm_pkg::GLITCH_RST;
			cfg_q.accept_min  <= mpfm_pkg::AMIN_RST;
			cfg_q.accept_max  <= mpfm_pkg::AMAX_RST;
			cfg_q.min_samples <= mpfm_pkg::MINS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				mpfm_pkg::CFG_GLITCH_MIN:  cfg_q.glitch_min  <= cfg_data;
				mpfm_pkg::CFG_ACCEPT_MIN:  cfg_q.accept_min  <= cfg_data;
				mpfm_pkg::CFG_ACCEPT_MAX:  cfg_q.accept_max  <= cfg_data;
				mpfm_pkg::CFG_MIN_SAMPLES: cfg_q.min_samples <= cfg_data[mpfm_pkg::MINS_W-1:0];
				default: ;
			endcase
		end
	end

	// classify and queue commands
	mpfm_front #(.CHANNELS(CHANNELS)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .qstat(qstat)
	);

	// advance pulses and reports against channel state
	mpfm_back #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .res(res), .bstat(bstat)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qstat.count) <= mpfm_pkg::QDEPTH)
		else $error("command queue count beyond its depth");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.frequency_hz <= mpfm_pkg::FREQ_NUM))
		else $error("frequency above one megahertz");

	a_load_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> bstat.reporting)
		else $error("result transfer loaded outside a report");
endmodule

// File: rtl/mpfm_front.sv
// Front end: accepts commands, drops pulses of absent channels, queues the rest.
// Depends on mpfm_pkg and mpfm_cmd_if.
`timescale 1ns / 1ps
module mpfm_front #(
	parameter int CHANNELS = mpfm_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	mpfm_cmd_if.sink           cmd,
	output logic               q_valid,
	output mpfm_pkg::cmd_t     q_cmd,
	input  logic               q_pop,
	output mpfm_pkg::qstat_t   qstat
);
	mpfm_pkg::cmd_t                  ent_q [mpfm_pkg::QDEPTH];
	logic                            wp_q, rp_q;
	logic [mpfm_pkg::QCNT_W-1:0]     cnt_q;
	logic                            keep, push, pop;

	assign cmd.ready = (cnt_q != mpfm_pkg::QCNT_W'(mpfm_pkg::QDEPTH));
	assign keep = (cmd.opcode == mpfm_pkg::OP_REPORT) || (32'(cmd.channel) < CHANNELS);
	assign push = cmd.valid && cmd.ready && keep;
	assign pop  = q_pop && q_valid;

	assign q_valid     = (cnt_q != '0);
	assign q_cmd       = ent_q[rp_q];
	assign qstat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{report: (cmd.opcode == mpfm_pkg::OP_REPORT),
				chan: cmd.channel, ts: cmd.timestamp_us};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// File: rtl/mpfm_back.sv
// Back end: per-channel edge tracking, interval ring memory, insertion sort,
// serial divider and result register. Depends on mpfm_pkg and mpfm_res_if.
`timescale 1ns / 1ps
module mpfm_back #(
	parameter int CHANNELS      = mpfm_pkg::CHANNELS_DEF,
	parameter int HISTORY_DEPTH = mpfm_pkg::HISTORY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mpfm_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  mpfm_pkg::cmd_t   q_cmd,
	output logic             q_pop,
	mpfm_res_if.source       res,
	output mpfm_pkg::bstat_t bstat
);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HW    = $clog2(HISTORY_DEPTH);
	localparam int NW    = $clog2(HISTORY_DEPTH + 1);
	localparam int DEPTH = CHANNELS * HISTORY_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = mpfm_pkg::IVL_W;
	localparam int DW    = mpfm_pkg::FREQ_W;
	localparam int DCW   = $clog2(DW);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIND  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_MED   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;

	// per-channel state
	logic [CHANNELS-1:0][mpfm_pkg::TS_W-1:0]  last_q;
	logic [CHANNELS-1:0][HW-1:0]              pos_q;
	logic [CHANNELS-1:0][mpfm_pkg::CNT_W-1:0] cnt_q;
	logic [CHANNELS-1:0]                      act_q;
	logic [CHANNELS-1:0][HISTORY_DEPTH-1:0]   rvld_q;

	logic [IW-1:0] mem [DEPTH];
	logic [IW-1:0] mem_rd_s1;
	logic          rd_ok_s1, rd_go_s1;

	logic [CW-1:0] ch_q;
	logic [HW-1:0] idx_q;
	logic [HISTORY_DEPTH-1:0][IW-1:0] sbuf_q;
	logic [NW-1:0] n_q;

	logic [IW-1:0] dvs_q, rem_q;
	logic [DW-1:0] quo_q, freq_q;
	logic [DCW-1:0] dcnt_q;

	// pulse decode
	logic [CW-1:0]            pc;
	logic [mpfm_pkg::TS_W-1:0] delta;
	logic                     glitch, accept, do_pulse, do_report;
	logic [HW-1:0]            pos_nx;
	logic [AW-1:0]            waddr, raddr;

	// report helpers
	logic [CW-1:0]  sel;
	logic           found, eload, rem_last;
	logic [IW-1:0]  rv;
	logic           rv_ins;
	logic [HISTORY_DEPTH-1:0][IW-1:0] sbuf_nx;
	logic [IW:0]    trial;
	logic           dbit;

	assign do_pulse  = (state_q == S_IDLE) && q_valid && !q_cmd.report;
	assign do_report = (state_q == S_IDLE) && q_valid && q_cmd.report;
	assign q_pop     = (state_q == S_IDLE);

	assign pc     = CW'(q_cmd.chan);
	assign delta  = q_cmd.ts - last_q[pc];
	assign glitch = delta < 32'(cfg.glitch_min);
	assign accept = (last_q[pc] != '0) && (delta >= 32'(cfg.accept_min)) &&
		(delta <= 32'(cfg.accept_max));
	assign pos_nx = (32'(pos_q[pc]) + 1 >= HISTORY_DEPTH) ? '0 : pos_q[pc] + 1'b1;
	assign waddr  = AW'(AW'(pc) * AW'(HISTORY_DEPTH) + AW'(pos_q[pc]));
	assign raddr  = AW'(AW'(ch_q) * AW'(HISTORY_DEPTH) + AW'(idx_q));

	always_comb begin
		sel = '0;
		for (int j = CHANNELS - 1; j >= 0; j--) begin
			if (act_q[j]) sel = CW'(j);
		end
	end
	assign found = |act_q;

	assign eload    = (state_q == S_EMIT) && (!res.valid || res.ready);
	assign rem_last = ((act_q & ~(CHANNELS'(1) << ch_q)) == '0);

	// sorted insertion of the interval returned by the ring
	assign rv     = rd_ok_s1 ? mem_rd_s1 : '0;
	assign rv_ins = rd_go_s1 && (rv != '0);
	always_comb begin
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			if ((32'(j) < 32'(n_q)) && (sbuf_q[j] <= rv)) sbuf_nx[j] = sbuf_q[j];
			else if (j == 0) sbuf_nx[j] = rv;
			else if ((32'(j - 1) < 32'(n_q)) && (sbuf_q[j-1] <= rv)) sbuf_nx[j] = rv;
			else sbuf_nx[j] = sbuf_q[j-1];
		end
	end

	assign dbit  = mpfm_pkg::FREQ_NUM[DCW'(DW - 1) - dcnt_q];
	assign trial = {rem_q, dbit};

	assign bstat.reporting = (state_q != S_IDLE);

	// ring memory
	always_ff @(posedge clk) begin
		if (do_pulse && !glitch && accept) mem[waddr] <= IW'(delta);
		mem_rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (rv_ins) sbuf_q <= sbuf_nx;
		if (state_q == S_MED) begin
			dvs_q <= sbuf_q[HW'(n_q >> 1)];
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= IW'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[IW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
		if (eload) begin
			res.out_channel    <= mpfm_pkg::CHAN_W'(ch_q);
			res.frequency_hz   <= freq_q;
			res.pulse_total    <= cnt_q[ch_q];
			res.last_of_report <= rem_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			last_q    <= '0;
			pos_q     <= '0;
			cnt_q     <= '0;
			act_q     <= '0;
			rvld_q    <= '0;
			rd_ok_s1  <= 1'b0;
			rd_go_s1  <= 1'b0;
			ch_q      <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			dcnt_q    <= '0;
			freq_q    <= '0;
			res.valid <= 1'b0;
		end else begin
			rd_ok_s1 <= rvld_q[ch_q][idx_q];
			rd_go_s1 <= (state_q == S_READ);
			if (rv_ins) n_q <= n_q + 1'b1;
			if (res.valid && res.ready && !eload) res.valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (do_pulse && !glitch) begin
						last_q[pc] <= q_cmd.ts;
						if (accept) begin
							rvld_q[pc][pos_q[pc]] <= 1'b1;
							pos_q[pc]             <= pos_nx;
							act_q[pc]             <= 1'b1;
							if (cnt_q[pc] != '1) cnt_q[pc] <= cnt_q[pc] + 1'b1;
						end
					end
					if (do_report) state_q <= S_FIND;
				end
				S_FIND: begin
					if (found) begin
						ch_q    <= sel;
						idx_q   <= '0;
						n_q     <= '0;
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (32'(idx_q) == HISTORY_DEPTH - 1) state_q <= S_DRAIN;
					else idx_q <= idx_q + 1'b1;
				end
				S_DRAIN: state_q <= S_MED;
				S_MED: begin
					dcnt_q <= '0;
					if ((n_q == '0) || (32'(n_q) < 32'(cfg.min_samples))) begin
						freq_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (32'(dcnt_q) == DW - 1) begin
						freq_q  <= {quo_q[DW-2:0], (trial >= {1'b0, dvs_q})};
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (eload) begin
						res.valid    <= 1'b1;
						last_q[ch_q] <= '0;
						pos_q[ch_q]  <= '0;
						cnt_q[ch_q]  <= '0;
						act_q[ch_q]  <= 1'b0;
						rvld_q[ch_q] <= '0;
						state_q      <= S_FIND;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: test/mpfm_tb_if.sv
// Testbench item types for commands and report lines.
// Depends on mpfm_pkg; the RTL interfaces are reused as they are.
`timescale 1ns / 1ps
package mpfm_tb_pkg;

	typedef struct packed {
		logic                        report;
		logic [mpfm_pkg::CHAN_W-1:0] chan;
		logic [mpfm_pkg::TS_W-1:0]   ts;
	} pulse_cmd_t;

	typedef struct packed {
		logic [mpfm_pkg::CHAN_W-1:0] chan;
		logic [mpfm_pkg::FREQ_W-1:0] freq;
		logic [mpfm_pkg::CNT_W-1:0]  total;
		logic                        last;
	} report_line_t;
endpackage

// File: test/testbench.sv
// Self-checking testbench for median_pulse_frequency_meter_core.
// Drives pulse and report commands, predicts report lines with an in-bench
// model of the meter and compares them; depends on mpfm_pkg and the interfaces.
`timescale 1ns / 1ps
module testbench;

	localparam int NCH = mpfm_pkg::CHANNELS_DEF;
	localparam int HD  = mpfm_pkg::HISTORY_DEF;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [mpfm_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [mpfm_pkg::CFG_DW-1:0] cfg_data = '0;

	mpfm_cmd_if cmd();
	mpfm_res_if res();

	median_pulse_frequency_meter_core dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: a private copy of the meter.
	logic [mpfm_pkg::IVL_W-1:0]  glitch_lim, win_lo, win_hi;
	logic [mpfm_pkg::MINS_W-1:0] need_samples;
	logic [mpfm_pkg::TS_W-1:0]   edge_time [NCH];
	logic [mpfm_pkg::IVL_W-1:0]  period_ring [NCH][HD];
	int                          ring_wr [NCH];
	logic [mpfm_pkg::CNT_W-1:0]  pulse_cnt [NCH];
	logic                        live [NCH];

	mpfm_tb_pkg::pulse_cmd_t   cmd_pending[$];
	mpfm_tb_pkg::report_line_t lines_due[$];
	int  mismatches = 0;
	bit  quiet_tail = 0;
	bit  feeding_done = 0;
	int  idle_cycles = 0;

	function automatic void wipe_channel(int c);
		edge_time[c] = '0;
		for (int i = 0; i < HD; i++)
			period_ring[c][i] = '0;
		ring_wr[c] = 0;
		pulse_cnt[c] = '0;
		live[c] = 1'b0;
	endfunction

	function automatic logic [mpfm_pkg::FREQ_W-1:0] median_hz(int c);
		logic [mpfm_pkg::IVL_W-1:0] v [$];
		logic [mpfm_pkg::IVL_W-1:0] mid;
		for (int i = 0; i < HD; i++)
			if (period_ring[c][i] != 0) v.push_back(period_ring[c][i]);
		if (v.size() == 0 || v.size() < need_samples) return '0;
		v.sort();
		mid = v[v.size() / 2];
		return mpfm_pkg::FREQ_W'(32'd1000000 / 32'(mid));
	endfunction

	// Work out the report lines that one command causes.
	function automatic void predict_meter(mpfm_tb_pkg::pulse_cmd_t k);
		logic [mpfm_pkg::TS_W-1:0] delta;
		int c, n;
		mpfm_tb_pkg::report_line_t r;
		if (k.report == mpfm_pkg::OP_PULSE) begin
			c = int'(k.chan);
			delta = k.ts - edge_time[c];
			if (delta < glitch_lim) return;
			if (edge_time[c] != 0 && delta >= win_lo && delta <= win_hi) begin
				period_ring[c][ring_wr[c]] = delta[mpfm_pkg::IVL_W-1:0];
				ring_wr[c] = (ring_wr[c] + 1) % HD;
				if (pulse_cnt[c] != 16'hFFFF) pulse_cnt[c]++;
				live[c] = 1'b1;
			end
			edge_time[c] = k.ts;
			return;
		end
		n = 0;
		for (c = 0; c < NCH; c++) begin
			if (!live[c]) continue;
			r.chan = mpfm_pkg::CHAN_W'(c);
			r.freq = median_hz(c);
			r.total = pulse_cnt[c];
			r.last = 1'b0;
			lines_due.push_back(r);
			n++;
			wipe_channel(c);
		end
		if (n > 0) lines_due[$].last = 1'b1;
	endfunction

	// Driver: present queued commands, with random idle bursts.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				predict_meter(cmd_pending.pop_front());
				if (!quiet_tail && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 13);
			end
			if (send_gap > 0 && !(cmd.valid && !cmd.ready)) begin
				send_gap = send_gap - 1;
				cmd.valid <= 1'b0;
			end else if (cmd_pending.size() > 0) begin
				cmd.valid <= 1'b1;
				cmd.opcode <= cmd_pending[0].report;
				cmd.channel <= cmd_pending[0].chan;
				cmd.timestamp_us <= cmd_pending[0].ts;
			end else
				cmd.valid <= 1'b0;
		end
	end

	// Monitor: accept report lines, compare with the oldest expectation.
	int sink_hold = 0;
	always @(posedge clk) begin
		mpfm_tb_pkg::report_line_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (lines_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected line: ch %0d hz %0d total %0d last %0d",
							res.out_channel, res.frequency_hz, res.pulse_total,
							res.last_of_report);
				end else begin
					want = lines_due.pop_front();
					if (res.out_channel !== want.chan || res.frequency_hz !== want.freq ||
					    res.pulse_total !== want.total || res.last_of_report !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp ch %0d hz %0d total %0d last %0d, ",
								"got ch %0d hz %0d total %0d last %0d"},
								want.chan, want.freq, want.total, want.last,
								res.out_channel, res.frequency_hz, res.pulse_total,
								res.last_of_report);
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				res.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				sink_hold <= $urandom_range(0, 12);
				res.ready <= 1'b0;
			end else
				res.ready <= 1'b1;
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || feeding_done)
			idle_cycles <= 0;
		else if (arst_n && (cmd_pending.size() > 0 || lines_due.size() > 0))
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [mpfm_pkg::CFG_IW-1:0] idx,
		logic [mpfm_pkg::CFG_DW-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			mpfm_pkg::CFG_GLITCH_MIN:  glitch_lim = val;
			mpfm_pkg::CFG_ACCEPT_MIN:  win_lo = val;
			mpfm_pkg::CFG_ACCEPT_MAX:  win_hi = val;
			mpfm_pkg::CFG_MIN_SAMPLES: need_samples = val[mpfm_pkg::MINS_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until every queued command is taken and every line has arrived,
	// then wait so that a trailing pulse drains.
	task automatic drain;
		while (cmd_pending.size() > 0 || cmd.valid || lines_due.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic void queue_cmd(logic op, int c, logic [mpfm_pkg::TS_W-1:0] ts);
		mpfm_tb_pkg::pulse_cmd_t k;
		k.report = op;
		k.chan = mpfm_pkg::CHAN_W'(c);
		k.ts = ts;
		cmd_pending.push_back(k);
	endfunction

	// A train of pulses on one channel, spaced by random gaps from lo to hi.
	task automatic pulse_train(int c, inout logic [mpfm_pkg::TS_W-1:0] t, input int n,
		input int lo, input int hi);
		for (int i = 0; i < n; i++) begin
			t = t + $urandom_range(lo, hi);
			queue_cmd(mpfm_pkg::OP_PULSE, c, t);
		end
	endtask

	logic [mpfm_pkg::TS_W-1:0] clock_us [NCH];

	initial begin
		cmd.valid = 1'b0; cmd.opcode = 1'b0; cmd.channel = '0; cmd.timestamp_us = '0;
		res.ready = 1'b0;
		glitch_lim = mpfm_pkg::GLITCH_RST; win_lo = mpfm_pkg::AMIN_RST;
		win_hi = mpfm_pkg::AMAX_RST;
		need_samples = mpfm_pkg::MINS_RST;
		for (int c = 0; c < NCH; c++) wipe_channel(c);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: report on idle, zero timestamp, glitch, wrap, window edges.
		queue_cmd(mpfm_pkg::OP_REPORT, 0, 32'h0);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'h0);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'd200);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'd210);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'd350);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'd800);
		queue_cmd(mpfm_pkg::OP_PULSE, 0, 32'd950);
		queue_cmd(mpfm_pkg::OP_PULSE, 1, 32'hFFFF_FF00);
		queue_cmd(mpfm_pkg::OP_PULSE, 1, 32'h0000_00C0);
		queue_cmd(mpfm_pkg::OP_PULSE, 1, 32'h0000_0200);
		queue_cmd(mpfm_pkg::OP_PULSE, 3, 32'hFFFF_FFFF);
		queue_cmd(mpfm_pkg::OP_PULSE, 3, 32'h0000_0119);
		queue_cmd(mpfm_pkg::OP_REPORT, 2, 32'hFFFF_FFFF);
		queue_cmd(mpfm_pkg::OP_REPORT, 1, 32'h0);
		drain();

		// Extreme window, zero glitch, zero accept minimum, min samples of one.
		write_reg(mpfm_pkg::CFG_GLITCH_MIN, 16'd0);
		write_reg(mpfm_pkg::CFG_ACCEPT_MIN, 16'd0);
		write_reg(mpfm_pkg::CFG_ACCEPT_MAX, 16'hFFFF);
		write_reg(mpfm_pkg::CFG_MIN_SAMPLES, 16'd1);
		queue_cmd(mpfm_pkg::OP_PULSE, 2, 32'd5);
		queue_cmd(mpfm_pkg::OP_PULSE, 2, 32'd5);
		queue_cmd(mpfm_pkg::OP_PULSE, 2, 32'd1);
		queue_cmd(mpfm_pkg::OP_PULSE, 2, 32'h0001_0000);
		queue_cmd(mpfm_pkg::OP_REPORT, 0, 32'h0);
		drain();

		// Random phases under several settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(mpfm_pkg::CFG_GLITCH_MIN, 16'd40);
					write_reg(mpfm_pkg::CFG_ACCEPT_MIN, 16'd150);
					write_reg(mpfm_pkg::CFG_ACCEPT_MAX, 16'd450);
					write_reg(mpfm_pkg::CFG_MIN_SAMPLES, 16'd3);
				end
				1: begin
					write_reg(mpfm_pkg::CFG_GLITCH_MIN, 16'hFFFF);
					write_reg(mpfm_pkg::CFG_ACCEPT_MIN, 16'hFFFF);
					write_reg(mpfm_pkg::CFG_ACCEPT_MAX, 16'hFFFF);
					write_reg(mpfm_pkg::CFG_MIN_SAMPLES, 16'd10);
				end
				2: begin
					write_reg(mpfm_pkg::CFG_ACCEPT_MIN, 16'd500);
					write_reg(mpfm_pkg::CFG_ACCEPT_MAX, 16'd100);
					write_reg(mpfm_pkg::CFG_GLITCH_MIN, 16'd10);
				end
				default: begin
					write_reg(mpfm_pkg::CFG_GLITCH_MIN, 16'($urandom_range(0, 100)));
					write_reg(mpfm_pkg::CFG_ACCEPT_MIN, 16'($urandom_range(1, 200)));
					write_reg(mpfm_pkg::CFG_ACCEPT_MAX, 16'($urandom_range(200, 65535)));
					write_reg(mpfm_pkg::CFG_MIN_SAMPLES, 16'($urandom_range(1, 10)));
				end
			endcase
			if (ph == 5) quiet_tail = 1;
			for (int c = 0; c < NCH; c++) clock_us[c] = $urandom;
			for (int i = 0; i < 2; i++) begin
				for (int c = 0; c < NCH; c++) begin
					if ($urandom_range(0, 3) == 0) continue;
					if (ph == 1)
						pulse_train(c, clock_us[c], $urandom_range(1, 8), 65535, 65535);
					else if ($urandom_range(0, 4) == 0)
						pulse_train(c, clock_us[c], 2, 0, 32'hFFFF_FFFF);
					else
						pulse_train(c, clock_us[c], $urandom_range(1, 8), 100, 500);
				end
				queue_cmd(mpfm_pkg::OP_REPORT, $urandom_range(0, 3), $urandom);
			end
			drain();
		end
		feeding_done = 1;
		repeat (200) @(posedge clk);
		if (mismatches == 0 && lines_due.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
